// ===== rtl/knn_pkg.sv =====
// Package for the k-nearest-neighbor query block: sizes, register indexes and beat types.
// No dependencies.
`timescale 1ns / 1ps
package knn_pkg;
  localparam int MaxPoints = 1024;
  localparam int MaxDims   = 16;
  localparam int MaxK      = 16;
  localparam int PtW   = $clog2(MaxPoints);
  localparam int DimW  = $clog2(MaxDims);
  localparam int KW    = $clog2(MaxK);
  localparam int AddrW = PtW + DimW;
  localparam int DistW = 36;
  localparam int CfgW  = 11;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegNumPoints = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNumDims   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNeighbor  = 2'd2;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [9:0]        point_index;
    logic [3:0]        dim_index;
    logic signed [15:0] coord_value;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]       query_point;
    logic [9:0]       neighbor_index;
    logic [DistW-1:0] sq_distance;
    logic             last;
    logic             bad_query;
  } out_beat_t;
endpackage

// ===== rtl/knn_stream_if.sv =====
// Valid/ready channel interfaces: one for input beats, one for result beats.
// Depends on knn_pkg.
`timescale 1ns / 1ps
interface knn_in_if;
  logic valid;
  logic ready;
  knn_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface knn_out_if;
  logic valid;
  logic ready;
  knn_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/knn_store.sv =====
// Point coordinate store: one write port and one registered read port.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [knn_pkg::AddrW-1:0]  waddr,
  input  logic signed [15:0]         wdata,
  input  logic [knn_pkg::AddrW-1:0]  raddr,
  output logic signed [15:0]         rdata
);
  logic signed [15:0] mem [knn_pkg::MaxPoints*knn_pkg::MaxDims];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/knn_best_list.sv =====
// Sorted list of the k best (distance, index) pairs with one insert per offer.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_best_list (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       offer,
  input  logic [knn_pkg::DistW-1:0]  cand_dist,
  input  logic [knn_pkg::PtW-1:0]    idx,
  input  logic [knn_pkg::KW:0]       k,
  input  logic [knn_pkg::KW-1:0]     rd_pos,
  output logic [knn_pkg::DistW-1:0]  rd_dist,
  output logic [knn_pkg::PtW-1:0]    rd_idx,
  output logic [knn_pkg::KW:0]       fill
);
  logic [knn_pkg::DistW-1:0] bd [knn_pkg::MaxK];
  logic [knn_pkg::PtW-1:0]   bi [knn_pkg::MaxK];
  logic [knn_pkg::MaxK-1:0]  closer;

  // Entry m is beaten by the candidate when it is valid and strictly farther.
  always_comb begin
    for (int m = 0; m < knn_pkg::MaxK; m++) begin
      closer[m] = (m < fill) && (cand_dist < bd[m]);
    end
  end

  assign rd_dist = bd[rd_pos];
  assign rd_idx  = bi[rd_pos];

  // Each slot keeps, shifts from below, or takes the candidate. The first free
  // slot is written too while the list is not full.
  always_ff @(posedge clk) begin
    if (offer) begin
      for (int m = 0; m < knn_pkg::MaxK; m++) begin
        if (m < k) begin
          if (closer[m] || m == fill) begin
            if (m == 0 || !closer[(m == 0) ? 0 : m-1]) begin
              bd[m] <= cand_dist;
              bi[m] <= idx;
            end else begin
              bd[m] <= bd[(m == 0) ? 0 : m-1];
              bi[m] <= bi[(m == 0) ? 0 : m-1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (offer && fill < k) begin
      fill <= fill + 1'b1;
    end
  end
endmodule

// ===== rtl/knn_neighbor_query.sv =====
// Top level of the brute-force k-nearest-neighbor query block.
// Depends on knn_pkg, knn_stream_if, knn_store and knn_best_list.
//
// Channel   Dir  Payload
// in_ch     in   kind, point_index, dim_index, coord_value
// out_ch    out  query_point, neighbor_index, sq_distance, last, bad_query
// cfg       in   cfg_we, cfg_index, cfg_data
//
// A load writes its coordinate into the store when taken. A good query steps through
// S_QRD (read the queried point), S_CRD (read the candidate) and S_ACC (accumulate)
// for each coordinate, paced by the single store read port, then S_OFFER to offer each
// candidate; S_WAIT starts the drain and S_EMIT sends each result beat. A bad query
// answers in the cycle after it is taken. One item is in work at a time; reset is
// synchronous and clears control; a stalled output beat holds in the output register.
`timescale 1ns / 1ps
module knn_neighbor_query (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [knn_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [knn_pkg::CfgW-1:0]     cfg_data,
  knn_in_if.sink                       in_ch,
  knn_out_if.source                    out_ch
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_QRD   = 7'b0000010,
    S_CRD   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_OFFER = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [10:0] num_points;
  logic [4:0]  num_dims;
  logic [4:0]  neighbor_count;
  logic [10:0] n_eff;
  logic [4:0]  d_eff;
  logic [knn_pkg::KW:0] k_eff;

  logic [knn_pkg::PtW-1:0]  qp;
  logic [knn_pkg::PtW:0]    cand;
  logic [knn_pkg::DimW:0]   d;
  logic signed [15:0]       qcoord;
  logic [knn_pkg::DistW-1:0] acc;
  logic                     rd_phase;
  logic [knn_pkg::KW:0]     emit_pos;

  logic [knn_pkg::AddrW-1:0] raddr;
  logic signed [15:0]        rdata;
  logic signed [16:0]        diff;
  logic [33:0]               sq;

  logic [knn_pkg::DistW-1:0] rd_dist;
  logic [knn_pkg::PtW-1:0]   rd_idx;
  logic [knn_pkg::KW:0]      fill;
  logic                      list_clear, list_offer;
  logic                      out_free;
  logic                      out_load;

  // The effective values saturate the registers into their legal ranges.
  assign n_eff = (num_points < 11'd2) ? 11'd2 :
                 (num_points > 11'(knn_pkg::MaxPoints)) ? 11'(knn_pkg::MaxPoints) : num_points;
  assign d_eff = (num_dims < 5'd1) ? 5'd1 :
                 (num_dims > 5'(knn_pkg::MaxDims)) ? 5'(knn_pkg::MaxDims) : num_dims;
  assign k_eff = (neighbor_count < 5'd1) ? 5'd1 :
                 (neighbor_count > 5'(knn_pkg::MaxK)) ? 5'(knn_pkg::MaxK) : neighbor_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points     <= 11'd1024;
      num_dims       <= 5'd16;
      neighbor_count <= 5'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        knn_pkg::RegNumPoints: num_points <= cfg_data;
        knn_pkg::RegNumDims:   num_dims <= cfg_data[4:0];
        knn_pkg::RegNeighbor:  neighbor_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Store read address: queried coordinate, then the candidate's.
  assign raddr = rd_phase ? {cand[knn_pkg::PtW-1:0], d[knn_pkg::DimW-1:0]}
                          : {qp, d[knn_pkg::DimW-1:0]};

  knn_store u_store (
    .clk   (clk),
    .we    (in_ch.valid && in_ch.ready && in_ch.data.kind == knn_pkg::KindLoad),
    .waddr ({in_ch.data.point_index, in_ch.data.dim_index}),
    .wdata (in_ch.data.coord_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign diff = 17'(rdata) - 17'(qcoord);
  assign sq   = 34'($signed(diff) * $signed(diff));

  knn_best_list u_list (
    .clk       (clk),
    .rst       (rst),
    .clear     (list_clear),
    .offer     (list_offer),
    .cand_dist (acc),
    .idx       (cand[knn_pkg::PtW-1:0]),
    .k         (k_eff),
    .rd_pos    (emit_pos[knn_pkg::KW-1:0]),
    .rd_dist   (rd_dist),
    .rd_idx    (rd_idx),
    .fill      (fill)
  );

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign list_offer  = (state == S_OFFER);
  assign list_clear  = (state == S_IDLE) && in_ch.valid && in_ch.ready;

  // A new result beat enters the output register on a bad query or a drain step.
  assign out_load = (in_ch.valid && in_ch.ready && in_ch.data.kind == knn_pkg::KindQuery &&
                     {1'b0, in_ch.data.point_index} >= n_eff) ||
                    (state == S_EMIT && out_free);

  // Sequencer: per coordinate read query, then candidate, accumulate; offer; drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      rd_phase <= 1'b0;
    end else begin
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && out_free && in_ch.data.kind == knn_pkg::KindQuery) begin
            qp <= in_ch.data.point_index;
            if ({1'b0, in_ch.data.point_index} >= n_eff) begin
              out_ch.data.query_point <= in_ch.data.point_index;
              out_ch.data.neighbor_index <= '0;
              out_ch.data.sq_distance <= '0;
              out_ch.data.last <= 1'b1;
              out_ch.data.bad_query <= 1'b1;
            end else begin
              cand <= (in_ch.data.point_index == '0) ? 11'd1 : 11'd0;
              d <= '0;
              acc <= '0;
              rd_phase <= 1'b0;
              state <= S_QRD;
            end
          end
        end
        S_QRD: begin
          rd_phase <= 1'b1;
          state <= S_CRD;
        end
        S_CRD: begin
          qcoord <= rdata;
          rd_phase <= 1'b0;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + 36'(sq);
          if (d + 1'b1 >= d_eff) begin
            state <= S_OFFER;
          end else begin
            d <= d + 1'b1;
            state <= S_QRD;
          end
        end
        S_OFFER: begin
          d <= '0;
          acc <= '0;
          if (cand + 1'b1 == {1'b0, qp} && cand + 2'd2 < n_eff) begin
            cand <= cand + 2'd2;
            state <= S_QRD;
          end else if (cand + 1'b1 < n_eff && cand + 1'b1 != {1'b0, qp}) begin
            cand <= cand + 1'b1;
            state <= S_QRD;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          emit_pos <= fill - 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.data.query_point <= qp;
            out_ch.data.neighbor_index <= rd_idx;
            out_ch.data.sq_distance <= rd_dist;
            out_ch.data.last <= (emit_pos == '0);
            out_ch.data.bad_query <= 1'b0;
            if (emit_pos == '0) state <= S_IDLE;
            else emit_pos <= emit_pos - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
